/* rtl/gn3_pkg.sv */
package gn3_pkg;

   localparam int unsigned TABLE_SIZE_DEFAULT    = 256;
   localparam int unsigned FRACTION_BITS_DEFAULT = 16;
   localparam int unsigned GRADIENT_BITS_DEFAULT = 16;

   localparam int unsigned NUM_AXES    = 3;
   localparam int unsigned NUM_CORNERS = 8;
   localparam int unsigned CORNER_W    = 3;
   localparam int unsigned NOISE_W     = 16;

   localparam logic signed [NOISE_W-1:0] NOISE_MAX = 16'sh7fff;
   localparam logic signed [NOISE_W-1:0] NOISE_MIN = 16'sh8000;

   typedef enum logic [2:0] {
      OP_EVALUATE   = 3'd0,
      OP_LOAD_GRAD  = 3'd1,
      OP_LOAD_XPERM = 3'd2,
      OP_LOAD_YPERM = 3'd3,
      OP_LOAD_ZPERM = 3'd4
   } opcode_type;

   typedef struct packed {
      logic        [2:0]  opcode;
      logic        [7:0]  table_index;
      logic        [7:0]  perm_value;
      logic signed [15:0] grad_x;
      logic signed [15:0] grad_y;
      logic signed [15:0] grad_z;
      logic signed [31:0] coord_x;
      logic signed [31:0] coord_y;
      logic signed [31:0] coord_z;
   } gn3_req_type;

   typedef struct packed {
      logic signed [NOISE_W-1:0] noise_value;
   } gn3_rsp_type;

endpackage

/* rtl/gn3_stream_if.sv */
interface gn3_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/gradient_noise_3d.sv */
// 3D gradient noise. Load transactions write one entry of the gradient table or of one of
// the three permutation tables; an entry must be loaded before an evaluate reads it. An
// evaluate transaction occupies the block until its result enters the output register:
// the eight lattice corners are issued one per cycle through the single-ported
// permutation and gradient memories, and a five-stage multiply-accumulate pipeline then
// drains. The result waits in the output register, and a load can be accepted while it is
// not yet taken.
module gradient_noise_3d
   import gn3_pkg::*;
#(
   parameter int unsigned TABLE_SIZE    = TABLE_SIZE_DEFAULT,
   parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEFAULT,
   parameter int unsigned GRADIENT_BITS = GRADIENT_BITS_DEFAULT
) (
   input logic           clock,
   input logic           reset,
   gn3_stream_if.sink    req_ch,
   gn3_stream_if.source  rsp_ch
);

   localparam int unsigned IDX_W     = $clog2(TABLE_SIZE);
   localparam int unsigned PERM_W    = (IDX_W < 8) ? IDX_W : 8;
   localparam int unsigned F         = FRACTION_BITS;
   localparam int unsigned GB        = GRADIENT_BITS;
   localparam int unsigned W_W       = F + 1;
   localparam int unsigned OFF_W     = F + 1;
   localparam int unsigned PROD_W    = GB + OFF_W;
   localparam int unsigned DSUM_W    = PROD_W + 2;
   localparam int unsigned DOT_W     = DSUM_W - (GB - 2);
   localparam int unsigned TERM_W    = DOT_W + W_W + 1;
   localparam int unsigned ACC_W     = TERM_W + 3;
   localparam int unsigned SUM_SHIFT = 2 * F - 15;
   localparam int unsigned WP_W      = 2 * W_W;

   localparam logic [CORNER_W-1:0] LAST_CORNER  = CORNER_W'(NUM_CORNERS - 1);
   localparam logic [CORNER_W-1:0] FIRST_CORNER = '0;
   localparam logic [W_W-1:0]      ONE_F        = {1'b1, {F{1'b0}}};
   localparam logic [F+1:0]        THREE_F      = {2'b11, {F{1'b0}}};

   function automatic logic [W_W-1:0] axis_weight(input logic upper, input logic [W_W-1:0] fd);
      axis_weight = upper ? fd : (ONE_F - fd);
   endfunction

   // control
   logic                req_fire;
   logic                eval_fire;
   logic [2:0]          op;
   logic [IDX_W-1:0]    load_idx;
   logic                busy_ff, busy_in;
   logic                run_ff, run_in;
   logic [CORNER_W-1:0] corner_ff, corner_in;

   // per-evaluate operands
   logic signed [31:0]  coord [NUM_AXES];
   logic [15:0]         grad_field [NUM_AXES];
   logic [IDX_W-1:0]    cell_ff [NUM_AXES];
   logic [F-1:0]        frac_ff [NUM_AXES];
   logic [2*F-1:0]      sq_prod [NUM_AXES];
   logic [F-1:0]        sq_ff [NUM_AXES];
   logic [F+1:0]        fade_t [NUM_AXES];
   logic [2*F+1:0]      fade_prod [NUM_AXES];
   logic [W_W-1:0]      fade_ff [NUM_AXES];

   // memories and read data
   logic [PERM_W-1:0]   perm_rd_ff [NUM_AXES];
   logic [3*GB-1:0]     grad_mem [TABLE_SIZE];
   logic [3*GB-1:0]     grad_rd_ff;
   logic [IDX_W-1:0]    grad_addr;
   logic                grad_we;
   logic [3*GB-1:0]     grad_wdata;

   // corner pipeline
   logic                s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;
   logic [CORNER_W-1:0] s1_corner_ff, s2_corner_ff, s3_corner_ff, s4_corner_ff, s5_corner_ff;
   logic signed [GB-1:0]     grad_val [NUM_AXES];
   logic signed [OFF_W-1:0]  offset [NUM_AXES];
   logic signed [PROD_W-1:0] prod_in [NUM_AXES];
   logic signed [PROD_W-1:0] prod_ff [NUM_AXES];
   logic [WP_W-1:0]          w01_prod;
   logic [W_W-1:0]           w01_ff;
   logic signed [DSUM_W-1:0] dot_sum;
   logic signed [DOT_W-1:0]  dot_in, dot_ff;
   logic [WP_W-1:0]          wt_prod;
   logic [W_W-1:0]           wt_in, wt_ff;
   logic signed [TERM_W-1:0] term_in, term_ff;
   logic signed [ACC_W-1:0]  acc_sum, acc_ff;
   logic signed [ACC_W-1:0]  acc_shifted;

   // result
   logic                      fin_valid;
   logic signed [NOISE_W-1:0] fin_value;
   logic                      rsp_free;
   logic                      cand_valid;
   logic signed [NOISE_W-1:0] cand_value;
   logic                      hold_valid_ff, hold_valid_in;
   logic signed [NOISE_W-1:0] hold_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [NOISE_W-1:0] rsp_value_ff;

   assign req_ch.ready = !busy_ff;
   assign req_fire     = req_ch.valid && !busy_ff;
   assign op           = req_ch.payload.opcode;
   assign eval_fire    = req_fire && (op == OP_EVALUATE);
   assign load_idx     = IDX_W'(req_ch.payload.table_index);

   assign coord[0]      = req_ch.payload.coord_x;
   assign coord[1]      = req_ch.payload.coord_y;
   assign coord[2]      = req_ch.payload.coord_z;
   assign grad_field[0] = req_ch.payload.grad_x;
   assign grad_field[1] = req_ch.payload.grad_y;
   assign grad_field[2] = req_ch.payload.grad_z;

   // sequencer: issue one corner per cycle
   always_comb begin
      run_in    = run_ff;
      corner_in = corner_ff;
      if (eval_fire) begin
         run_in    = 1'b1;
         corner_in = FIRST_CORNER;
      end else if (run_ff) begin
         corner_in = corner_ff + CORNER_W'(1);
         if (corner_ff == LAST_CORNER) begin
            run_in = 1'b0;
         end
      end
   end

   always_comb begin
      busy_in = busy_ff;
      if (eval_fire) begin
         busy_in = 1'b1;
      end else if (cand_valid && rsp_free) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         run_ff    <= 1'b0;
         corner_ff <= FIRST_CORNER;
      end else begin
         busy_ff   <= busy_in;
         run_ff    <= run_in;
         corner_ff <= corner_in;
      end
   end

   // cell, fraction and fade per axis
   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         sq_prod[a]   = (2*F)'(frac_ff[a]) * (2*F)'(frac_ff[a]);
         fade_t[a]    = THREE_F - {1'b0, frac_ff[a], 1'b0};
         fade_prod[a] = (2*F+2)'(sq_ff[a]) * (2*F+2)'(fade_t[a]);
      end
   end

   always_ff @(posedge clock) begin
      for (int a = 0; a < NUM_AXES; a++) begin
         if (eval_fire) begin
            cell_ff[a] <= IDX_W'(coord[a] >>> F);
            frac_ff[a] <= coord[a][F-1:0];
         end
         sq_ff[a]   <= sq_prod[a][2*F-1:F];
         fade_ff[a] <= fade_prod[a][2*F:F];
      end
   end

   // permutation memories, one per axis
   for (genvar a = 0; a < NUM_AXES; a++) begin : g_perm
      localparam opcode_type LOAD_OP = (a == 0) ? OP_LOAD_XPERM :
                                       (a == 1) ? OP_LOAD_YPERM : OP_LOAD_ZPERM;
      logic [PERM_W-1:0] perm_mem [TABLE_SIZE];
      logic [IDX_W-1:0]  perm_addr;
      logic              perm_we;

      assign perm_we   = req_fire && (op == LOAD_OP);
      assign perm_addr = run_ff ? (cell_ff[a] + IDX_W'(corner_ff[NUM_AXES-1-a])) : load_idx;

      always_ff @(posedge clock) begin
         if (perm_we) begin
            perm_mem[perm_addr] <= PERM_W'(req_ch.payload.perm_value);
         end
         perm_rd_ff[a] <= perm_mem[perm_addr];
      end
   end

   // gradient memory
   assign grad_we    = req_fire && (op == OP_LOAD_GRAD);
   assign grad_wdata = {GB'(grad_field[2]), GB'(grad_field[1]), GB'(grad_field[0])};
   assign grad_addr  = s1_valid_ff ? IDX_W'(perm_rd_ff[0] ^ perm_rd_ff[1] ^ perm_rd_ff[2])
                                   : load_idx;

   always_ff @(posedge clock) begin
      if (grad_we) begin
         grad_mem[grad_addr] <= grad_wdata;
      end
      grad_rd_ff <= grad_mem[grad_addr];
   end

   // corner datapath
   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         grad_val[a] = $signed(grad_rd_ff[a*GB +: GB]);
         offset[a]   = $signed({s2_corner_ff[NUM_AXES-1-a], frac_ff[a]});
         prod_in[a]  = PROD_W'(grad_val[a]) * PROD_W'(offset[a]);
      end
      w01_prod = WP_W'(axis_weight(s2_corner_ff[2], fade_ff[0]))
               * WP_W'(axis_weight(s2_corner_ff[1], fade_ff[1]));
      dot_sum  = DSUM_W'(prod_ff[0]) + DSUM_W'(prod_ff[1]) + DSUM_W'(prod_ff[2]);
      dot_in   = DOT_W'(dot_sum >>> (GB - 2));
      wt_prod  = WP_W'(w01_ff) * WP_W'(axis_weight(s3_corner_ff[0], fade_ff[2]));
      wt_in    = wt_prod[2*F:F];
      term_in  = TERM_W'(dot_ff) * TERM_W'($signed({1'b0, wt_ff}));
      acc_sum  = ((s5_corner_ff == FIRST_CORNER) ? ACC_W'(0) : acc_ff) + ACC_W'(term_ff);
      acc_shifted = acc_sum >>> SUM_SHIFT;
      if ((acc_shifted[ACC_W-1:NOISE_W-1] == '0) || (acc_shifted[ACC_W-1:NOISE_W-1] == '1)) begin
         fin_value = acc_shifted[NOISE_W-1:0];
      end else if (acc_shifted[ACC_W-1]) begin
         fin_value = NOISE_MIN;
      end else begin
         fin_value = NOISE_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= run_ff;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_corner_ff <= corner_ff;
      s2_corner_ff <= s1_corner_ff;
      s3_corner_ff <= s2_corner_ff;
      s4_corner_ff <= s3_corner_ff;
      s5_corner_ff <= s4_corner_ff;
      for (int a = 0; a < NUM_AXES; a++) begin
         prod_ff[a] <= prod_in[a];
      end
      w01_ff  <= w01_prod[2*F:F];
      dot_ff  <= dot_in;
      wt_ff   <= wt_in;
      term_ff <= term_in;
      if (s5_valid_ff) begin
         acc_ff <= acc_sum;
      end
   end

   // result: hold stage in front of the output register
   assign fin_valid  = s5_valid_ff && (s5_corner_ff == LAST_CORNER);
   assign rsp_free   = !rsp_valid_ff || rsp_ch.ready;
   assign cand_valid = hold_valid_ff || fin_valid;
   assign cand_value = hold_valid_ff ? hold_ff : fin_value;

   assign rsp_valid_in  = rsp_free ? cand_valid : rsp_valid_ff;
   assign hold_valid_in = cand_valid && !rsp_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= cand_value;
      if (rsp_free && cand_valid) begin
         rsp_value_ff <= cand_value;
      end
   end

   assign rsp_ch.valid               = rsp_valid_ff;
   assign rsp_ch.payload.noise_value = rsp_value_ff;

`ifndef NO_ASSERTIONS
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> !(run_ff || s1_valid_ff || s2_valid_ff || s3_valid_ff || s4_valid_ff
                     || s5_valid_ff || hold_valid_ff))
      else $error("pipeline active while idle");

   a_hold_full: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff |-> rsp_valid_ff)
      else $error("result held while output register empty");

   a_start: assert property (@(posedge clock) disable iff (reset)
      eval_fire |=> (run_ff && (corner_ff == FIRST_CORNER)))
      else $error("evaluate did not start at first corner");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      fin_valid |=> !(run_ff || s1_valid_ff || s2_valid_ff || s3_valid_ff || s4_valid_ff
                      || s5_valid_ff))
      else $error("corner pipeline not empty after last corner");

   a_result: assert property (@(posedge clock) disable iff (reset)
      fin_valid |=> rsp_valid_ff)
      else $error("finished result lost");
`endif

endmodule

/* dv/gn3_checker.sv */
`timescale 1ns / 1ps
module gn3_checker
   import gn3_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  gn3_req_type req_payload,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  gn3_rsp_type rsp_payload,
   output int unsigned fail_count,
   output int unsigned pending_count
);

   localparam int unsigned ENTRIES = TABLE_SIZE_DEFAULT;
   localparam int unsigned FB      = FRACTION_BITS_DEFAULT;
   localparam int unsigned GB      = GRADIENT_BITS_DEFAULT;
   localparam longint      UNIT    = longint'(1) << FB;

   logic signed [15:0]        grad_tab [NUM_AXES][ENTRIES];
   logic        [7:0]         perm_tab [NUM_AXES][ENTRIES];
   logic signed [NOISE_W-1:0] noise_expected [$];
   logic signed [NOISE_W-1:0] oldest_noise;
   int unsigned               mismatches = 0;

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   function automatic longint smooth_fade(longint f);
      longint sq;
      sq = (f * f) >>> FB;
      return (sq * (3 * UNIT - 2 * f)) >>> FB;
   endfunction

   function automatic logic signed [NOISE_W-1:0] predict_noise(gn3_req_type t);
      logic [31:0] crd      [NUM_AXES];
      logic [7:0]  cell_idx [NUM_AXES];
      logic [7:0]  ix       [NUM_AXES];
      longint      frac     [NUM_AXES];
      longint      fd       [NUM_AXES];
      longint      w        [NUM_AXES];
      longint      off, dot, wt, acc;
      logic [7:0]  g;
      int          d;
      crd[0] = t.coord_x;
      crd[1] = t.coord_y;
      crd[2] = t.coord_z;
      acc = 0;
      for (int a = 0; a < NUM_AXES; a++) begin
         cell_idx[a] = crd[a][FB+7:FB];
         frac[a]     = longint'(crd[a][FB-1:0]);
         fd[a]       = smooth_fade(frac[a]);
      end
      for (int c = 0; c < NUM_CORNERS; c++) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            ix[a] = cell_idx[a] + 8'((c >> a) & 1);
         end
         g   = perm_tab[0][ix[0]] ^ perm_tab[1][ix[1]] ^ perm_tab[2][ix[2]];
         dot = 0;
         for (int a = 0; a < NUM_AXES; a++) begin
            d    = (c >> a) & 1;
            off  = frac[a] - (d != 0 ? UNIT : 0);
            dot += longint'(grad_tab[a][g]) * off;
            w[a] = (d != 0) ? fd[a] : UNIT - fd[a];
         end
         dot  = dot >>> (GB - 2);
         wt   = (w[0] * w[1]) >>> FB;
         wt   = (wt * w[2]) >>> FB;
         acc += dot * wt;
      end
      acc = acc >>> (2 * FB - 15);
      if (acc > longint'(NOISE_MAX)) return NOISE_MAX;
      if (acc < longint'(NOISE_MIN)) return NOISE_MIN;
      return NOISE_W'(acc);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         noise_expected.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (noise_expected.size() == 0) begin
               $error("noise_value: expected none, actual %0d", rsp_payload.noise_value);
               mismatches++;
            end else begin
               oldest_noise = noise_expected.pop_front();
               if (rsp_payload.noise_value !== oldest_noise) begin
                  $error("noise_value: expected %0d, actual %0d",
                         oldest_noise, rsp_payload.noise_value);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready) begin
            case (req_payload.opcode)
               OP_EVALUATE: begin
                  noise_expected.push_back(predict_noise(req_payload));
               end
               OP_LOAD_GRAD: begin
                  grad_tab[0][req_payload.table_index] = req_payload.grad_x;
                  grad_tab[1][req_payload.table_index] = req_payload.grad_y;
                  grad_tab[2][req_payload.table_index] = req_payload.grad_z;
               end
               OP_LOAD_XPERM: perm_tab[0][req_payload.table_index] = req_payload.perm_value;
               OP_LOAD_YPERM: perm_tab[1][req_payload.table_index] = req_payload.perm_value;
               OP_LOAD_ZPERM: perm_tab[2][req_payload.table_index] = req_payload.perm_value;
               default: ;
            endcase
         end
      end
      fail_count    <= mismatches;
      pending_count <= noise_expected.size();
   end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
   import gn3_pkg::*;

   localparam int unsigned ITEM_TARGET    = 700;
   localparam int unsigned HOLD_EVERY     = 175;
   localparam int unsigned WATCHDOG_LIMIT = 4000;
   localparam int unsigned SETTLE_CYCLES  = 40;
   localparam int unsigned ENTRIES        = TABLE_SIZE_DEFAULT;
   localparam int unsigned FB             = FRACTION_BITS_DEFAULT;
   localparam int unsigned FIRST_SPARE_OP = int'(OP_LOAD_ZPERM) + 1;
   localparam int unsigned LAST_SPARE_OP  = (1 << $bits(opcode_type)) - 1;
   localparam logic signed [15:0] GRAD_TOP    = 16'sh7fff;
   localparam logic signed [15:0] GRAD_BOTTOM = 16'sh8000;

   typedef enum int unsigned {
      IDLE_MIXED,
      IDLE_NONE,
      IDLE_HEAVY
   } idle_style_type;

   logic           clock = 1'b0;
   logic           reset = 1'b1;
   idle_style_type idle_style = IDLE_MIXED;
   int unsigned    chk_fail;
   int unsigned    chk_pending;
   int unsigned    quiet_cycles = 0;
   int unsigned    load_count   = 0;
   int unsigned    eval_count   = 0;
   int unsigned    spare_count  = 0;
   logic [7:0]     perm_shadow [NUM_AXES][ENTRIES];
   bit             perm_known  [NUM_AXES][ENTRIES];
   bit             grad_known  [ENTRIES];

   gn3_stream_if #(.payload_type(gn3_req_type)) req_ch ();
   gn3_stream_if #(.payload_type(gn3_rsp_type)) rsp_ch ();

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   gradient_noise_3d dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   gn3_checker noise_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_ready     (req_ch.ready),
      .req_payload   (req_ch.payload),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_payload   (rsp_ch.payload),
      .fail_count    (chk_fail),
      .pending_count (chk_pending)
   );

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (idle_style == IDLE_NONE) return 0;
      r = $urandom_range(0, 99);
      if (idle_style == IDLE_HEAVY) r = 50 + r / 2;
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic signed [15:0] rand_grad();
      if ($urandom_range(0, 99) < 85) return 16'(int'($urandom_range(0, 32768)) - 16384);
      return 16'($urandom);
   endfunction

   function automatic logic [31:0] rand_coord();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 40) return $urandom;
      if (r < 60) return 32'(int'($urandom_range(0, 8 << FB)) - (4 << FB));
      if (r < 75) return {16'($urandom), 16'h0000};
      if (r < 85) return {16'($urandom), 16'hffff};
      case ($urandom_range(0, 4))
         0:       return 32'h7fffffff;
         1:       return 32'h80000000;
         2:       return 32'h00000000;
         3:       return 32'hffffffff;
         default: return 32'h00008000;
      endcase
   endfunction

   function automatic gn3_req_type random_fill();
      gn3_req_type it;
      it.opcode      = 3'($urandom);
      it.table_index = 8'($urandom);
      it.perm_value  = 8'($urandom);
      it.grad_x      = 16'($urandom);
      it.grad_y      = 16'($urandom);
      it.grad_z      = 16'($urandom);
      it.coord_x     = $urandom;
      it.coord_y     = $urandom;
      it.coord_z     = $urandom;
      return it;
   endfunction

   function automatic logic [7:0] corner_slot(logic [7:0] cx, logic [7:0] cy,
                                              logic [7:0] cz, int unsigned corner);
      logic [7:0] ix, iy, iz;
      ix = cx + 8'(corner & 1);
      iy = cy + 8'((corner >> 1) & 1);
      iz = cz + 8'((corner >> 2) & 1);
      return perm_shadow[0][ix] ^ perm_shadow[1][iy] ^ perm_shadow[2][iz];
   endfunction

   task automatic send_item(gn3_req_type it);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= it;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (it.opcode == OP_EVALUATE) eval_count++;
      else if (it.opcode <= OP_LOAD_ZPERM) load_count++;
      else spare_count++;
   endtask

   task automatic put_perm(int unsigned axis, logic [7:0] idx, logic [7:0] val);
      gn3_req_type it;
      it = random_fill();
      case (axis)
         0:       it.opcode = OP_LOAD_XPERM;
         1:       it.opcode = OP_LOAD_YPERM;
         default: it.opcode = OP_LOAD_ZPERM;
      endcase
      it.table_index = idx;
      it.perm_value  = val;
      send_item(it);
      perm_shadow[axis][idx] = val;
      perm_known[axis][idx]  = 1'b1;
   endtask

   task automatic put_grad(logic [7:0] idx, logic signed [15:0] gx,
                           logic signed [15:0] gy, logic signed [15:0] gz);
      gn3_req_type it;
      it             = random_fill();
      it.opcode      = OP_LOAD_GRAD;
      it.table_index = idx;
      it.grad_x      = gx;
      it.grad_y      = gy;
      it.grad_z      = gz;
      send_item(it);
      grad_known[idx] = 1'b1;
   endtask

   // load every entry the eight corners touch before the evaluate goes out
   task automatic eval_at(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      gn3_req_type it;
      logic [7:0]  cell_idx [NUM_AXES];
      logic [7:0]  ix, g;
      cell_idx[0] = x[FB+7:FB];
      cell_idx[1] = y[FB+7:FB];
      cell_idx[2] = z[FB+7:FB];
      for (int a = 0; a < NUM_AXES; a++) begin
         for (int d = 0; d < 2; d++) begin
            ix = cell_idx[a] + 8'(d);
            if (!perm_known[a][ix]) put_perm(a, ix, 8'($urandom));
         end
      end
      for (int c = 0; c < NUM_CORNERS; c++) begin
         g = corner_slot(cell_idx[0], cell_idx[1], cell_idx[2], c);
         if (!grad_known[g]) put_grad(g, rand_grad(), rand_grad(), rand_grad());
      end
      it         = random_fill();
      it.opcode  = OP_EVALUATE;
      it.coord_x = x;
      it.coord_y = y;
      it.coord_z = z;
      send_item(it);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (chk_pending != 0) @(posedge clock);
   endtask

   initial begin
      int unsigned n;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         n = pick_gap();
         if (n != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   initial begin
      gn3_req_type it;
      logic [7:0]  g;
      int unsigned next_hold;
      int unsigned r;
      req_ch.valid   <= 1'b0;
      req_ch.payload <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // corners of cell 255 wrap to 0; eight distinct gradients, signs push every dot positive
      put_perm(0, 8'hff, 8'hff);
      put_perm(0, 8'h00, 8'hfe);
      put_perm(1, 8'hff, 8'h00);
      put_perm(1, 8'h00, 8'h02);
      put_perm(2, 8'hff, 8'h00);
      put_perm(2, 8'h00, 8'h04);
      for (int c = 0; c < NUM_CORNERS; c++) begin
         g = corner_slot(8'hff, 8'hff, 8'hff, c);
         put_grad(g, c[0] ? GRAD_BOTTOM : GRAD_TOP, c[1] ? GRAD_BOTTOM : GRAD_TOP,
                  c[2] ? GRAD_BOTTOM : GRAD_TOP);
      end
      eval_at(32'hffff8000, 32'hffff8000, 32'hffff8000);
      // swap the permutations so every corner sees the opposite gradient
      put_perm(0, 8'hff, 8'hfe);
      put_perm(0, 8'h00, 8'hff);
      put_perm(1, 8'hff, 8'h02);
      put_perm(1, 8'h00, 8'h00);
      put_perm(2, 8'hff, 8'h04);
      put_perm(2, 8'h00, 8'h00);
      eval_at(32'hffff8000, 32'hffff8000, 32'hffff8000);
      eval_at(32'h7fffffff, 32'hffff0000, 32'hffffffff);
      for (int op = FIRST_SPARE_OP; op <= LAST_SPARE_OP; op++) begin
         it        = random_fill();
         it.opcode = 3'(op);
         send_item(it);
      end
      wait_drained();

      next_hold = HOLD_EVERY;
      while (load_count + eval_count < ITEM_TARGET) begin
         idle_style = idle_style_type'(((load_count + eval_count) / 100) % 3);
         r = $urandom_range(0, 99);
         if (r < 72) begin
            eval_at(rand_coord(), rand_coord(), rand_coord());
         end else if (r < 92) begin
            if ($urandom_range(0, 3) == 0) begin
               put_grad(8'($urandom), rand_grad(), rand_grad(), rand_grad());
            end else begin
               put_perm($urandom_range(0, 2), 8'($urandom), 8'($urandom));
            end
         end else begin
            it        = random_fill();
            it.opcode = 3'($urandom_range(FIRST_SPARE_OP, LAST_SPARE_OP));
            send_item(it);
         end
         if (load_count + eval_count >= next_hold) begin
            wait_drained();
            next_hold += HOLD_EVERY;
         end
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Covered %0d evaluates, %0d table loads and %0d unused opcodes,",
               eval_count, load_count, spare_count);
      $display("with saturation both ways, cell wrap and mixed, no-idle and heavy-idle phases.");
      if (chk_fail == 0 && chk_pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/gn3_pkg.sv
rtl/gn3_stream_if.sv
rtl/gradient_noise_3d.sv
dv/gn3_checker.sv
dv/tb_top.sv
